// ===== src/bcr_pkg.sv =====
// bcr_pkg: shared types, constants and the control program of the bisection cubic root finder
// depends on nothing; used by every other file of the block but bcr_ifs

package bcr_pkg;

	localparam int DIGIT_BITS   = 32;
	localparam int OFFSET_BITS  = 32;
	localparam int TOL_BITS     = 31;
	localparam int CNT_BITS     = 7;
	localparam int MAX_HALVINGS = 64;
	localparam int PC_BITS      = 4;
	localparam int CFG_IDX_BITS = 1;

	localparam logic signed [OFFSET_BITS-1:0] CUBE_OFFSET_RESET = 32'sd419430400;
	localparam logic [TOL_BITS-1:0]           TOLERANCE_RESET   = 31'd1678;

	localparam logic [CFG_IDX_BITS-1:0] CFG_CUBE_OFFSET = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE   = 1'b1;

	typedef enum logic [3:0] {
		OP_WAIT,
		OP_SETX_A,
		OP_SETX_B,
		OP_SQ,
		OP_CU,
		OP_SIGN_A,
		OP_SIGN_B,
		OP_CHECK,
		OP_INIT,
		OP_TEST,
		OP_DECIDE,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_NO_INPUT,
		C_SQ_MORE,
		C_CU_MORE,
		C_SAME_SIGN,
		C_STOP,
		C_FC_NONZERO,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t                op;
		cond_t              cond;
		logic [PC_BITS-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic no_input;
		logic sq_more;
		logic cu_more;
		logic same_sign;
		logic stop;
		logic fc_nonzero;
		logic out_busy;
	} status_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} sgn_t;

	// program steps
	localparam logic [PC_BITS-1:0] ST_SETX_A = 4'd0;
	localparam logic [PC_BITS-1:0] ST_SQ_A   = 4'd1;
	localparam logic [PC_BITS-1:0] ST_CU_A   = 4'd2;
	localparam logic [PC_BITS-1:0] ST_SIGN_A = 4'd3;
	localparam logic [PC_BITS-1:0] ST_SETX_B = 4'd4;
	localparam logic [PC_BITS-1:0] ST_SQ_B   = 4'd5;
	localparam logic [PC_BITS-1:0] ST_CU_B   = 4'd6;
	localparam logic [PC_BITS-1:0] ST_SIGN_B = 4'd7;
	localparam logic [PC_BITS-1:0] ST_CHECK  = 4'd8;
	localparam logic [PC_BITS-1:0] ST_INIT   = 4'd9;
	localparam logic [PC_BITS-1:0] ST_TEST   = 4'd10;
	localparam logic [PC_BITS-1:0] ST_SQ_C   = 4'd11;
	localparam logic [PC_BITS-1:0] ST_CU_C   = 4'd12;
	localparam logic [PC_BITS-1:0] ST_DECIDE = 4'd13;
	localparam logic [PC_BITS-1:0] ST_EMIT   = 4'd14;
	localparam logic [PC_BITS-1:0] ST_WAIT   = 4'd15;

	// jump to target when the condition holds, else fall through (wait wraps to step zero)
	function automatic ctrl_t rom_word(logic [PC_BITS-1:0] pc);
		ctrl_t w;
		unique case (pc)
			ST_SETX_A: w = '{op: OP_SETX_A, cond: C_NEVER,      target: ST_SETX_A};
			ST_SQ_A:   w = '{op: OP_SQ,     cond: C_SQ_MORE,    target: ST_SQ_A};
			ST_CU_A:   w = '{op: OP_CU,     cond: C_CU_MORE,    target: ST_CU_A};
			ST_SIGN_A: w = '{op: OP_SIGN_A, cond: C_NEVER,      target: ST_SIGN_A};
			ST_SETX_B: w = '{op: OP_SETX_B, cond: C_NEVER,      target: ST_SETX_B};
			ST_SQ_B:   w = '{op: OP_SQ,     cond: C_SQ_MORE,    target: ST_SQ_B};
			ST_CU_B:   w = '{op: OP_CU,     cond: C_CU_MORE,    target: ST_CU_B};
			ST_SIGN_B: w = '{op: OP_SIGN_B, cond: C_NEVER,      target: ST_SIGN_B};
			ST_CHECK:  w = '{op: OP_CHECK,  cond: C_SAME_SIGN,  target: ST_EMIT};
			ST_INIT:   w = '{op: OP_INIT,   cond: C_NEVER,      target: ST_INIT};
			ST_TEST:   w = '{op: OP_TEST,   cond: C_STOP,       target: ST_EMIT};
			ST_SQ_C:   w = '{op: OP_SQ,     cond: C_SQ_MORE,    target: ST_SQ_C};
			ST_CU_C:   w = '{op: OP_CU,     cond: C_CU_MORE,    target: ST_CU_C};
			ST_DECIDE: w = '{op: OP_DECIDE, cond: C_FC_NONZERO, target: ST_TEST};
			ST_EMIT:   w = '{op: OP_EMIT,   cond: C_OUT_BUSY,   target: ST_EMIT};
			ST_WAIT:   w = '{op: OP_WAIT,   cond: C_NO_INPUT,   target: ST_WAIT};
			default:   w = '{op: OP_WAIT,   cond: C_NO_INPUT,   target: ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

// ===== src/bcr_ifs.sv =====
// bcr_in_if / bcr_out_if: valid-ready channels for intervals and results
// depends on nothing

interface bcr_in_if #(parameter int WORD_BITS = 32) ();
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] lower_bound;
	logic signed [WORD_BITS-1:0] upper_bound;

	modport source(output valid, lower_bound, upper_bound, input ready);
	modport sink(input valid, lower_bound, upper_bound, output ready);
endinterface

interface bcr_out_if #(parameter int WORD_BITS = 32) ();
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] root_estimate;
	logic [6:0]                  halving_count;
	logic                        no_root;

	modport source(output valid, root_estimate, halving_count, no_root, input ready);
	modport sink(input valid, root_estimate, halving_count, no_root, output ready);
endinterface

// ===== src/bcr_sequencer.sv =====
// bcr_sequencer: step counter over the control program with conditional jumps
// depends on bcr_pkg

module bcr_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  bcr_pkg::status_t status,
	output bcr_pkg::ctrl_t   ctrl
);

	logic [bcr_pkg::PC_BITS-1:0] pc_q;
	logic                        taken;

	assign ctrl = bcr_pkg::rom_word(pc_q);

	always_comb begin
		case (ctrl.cond)
			bcr_pkg::C_NO_INPUT:   taken = status.no_input;
			bcr_pkg::C_SQ_MORE:    taken = status.sq_more;
			bcr_pkg::C_CU_MORE:    taken = status.cu_more;
			bcr_pkg::C_SAME_SIGN:  taken = status.same_sign;
			bcr_pkg::C_STOP:       taken = status.stop;
			bcr_pkg::C_FC_NONZERO: taken = status.fc_nonzero;
			bcr_pkg::C_OUT_BUSY:   taken = status.out_busy;
			default:               taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= bcr_pkg::ST_WAIT;
		end else if (taken) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

// ===== src/bcr_datapath.sv =====
// bcr_datapath: interval registers, shared digit multiplier for x cubed, sign compare
// depends on bcr_pkg and the channel interfaces

module bcr_datapath #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bcr_pkg::ctrl_t                        ctrl,
	output bcr_pkg::status_t                      status,
	input  logic signed [bcr_pkg::OFFSET_BITS-1:0] cube_offset,
	input  logic [bcr_pkg::TOL_BITS-1:0]          tolerance,
	bcr_in_if.sink                                in_ch,
	bcr_out_if.source                             out_ch
);

	localparam int DIG       = bcr_pkg::DIGIT_BITS;
	localparam int SQ_DIGITS = (WORD_BITS + DIG - 1) / DIG;
	localparam int CU_DIGITS = (2 * WORD_BITS + DIG - 1) / DIG;
	localparam int DIGW      = (CU_DIGITS > 1) ? $clog2(CU_DIGITS) : 1;
	localparam int ACC_W     = 3 * WORD_BITS;
	localparam int SQ_W      = 2 * WORD_BITS;
	localparam int PROD_W    = WORD_BITS + DIG;
	localparam int OFF_W     = bcr_pkg::OFFSET_BITS + 2 * FRAC_BITS;
	localparam int CMP_W     = ((ACC_W > OFF_W) ? ACC_W : OFF_W) + 2;
	localparam int WID_W     = (WORD_BITS + 1 > bcr_pkg::TOL_BITS + 1) ?
	                           WORD_BITS + 1 : bcr_pkg::TOL_BITS + 1;
	localparam int CNT       = bcr_pkg::CNT_BITS;

	logic signed [WORD_BITS-1:0] a_q, b_q, c_q;
	logic [WORD_BITS-1:0]        mag_q;
	logic                        xneg_q;
	logic [SQ_W-1:0]             sq_q;
	logic [ACC_W-1:0]            acc_q;
	logic [DIGW-1:0]             dig_q;
	logic [CNT-1:0]              n_q;
	logic                        nr_q;
	bcr_pkg::sgn_t               fa_q, fb_q;
	logic                        out_valid_q;
	logic signed [WORD_BITS-1:0] out_root_q;
	logic [CNT-1:0]              out_cnt_q;
	logic                        out_nr_q;

	logic [SQ_DIGITS*DIG-1:0]    mag_pad;
	logic [CU_DIGITS*DIG-1:0]    sq_pad;
	logic [DIG-1:0]              digit;
	logic [PROD_W-1:0]           prod;
	logic [ACC_W-1:0]            acc_next;
	logic                        sq_last, cu_last;
	logic signed [CMP_W-1:0]     cube_s, off_s;
	bcr_pkg::sgn_t               sgn_now;
	logic signed [WORD_BITS:0]   sum;
	logic signed [WORD_BITS-1:0] mid;
	logic signed [WID_W-1:0]     width_s, tol_s;
	logic                        go;
	logic                        accept, out_busy;
	logic                        fa_fc_opposite;

	// shared multiply-accumulate, one digit a step
	assign mag_pad  = (SQ_DIGITS*DIG)'(mag_q);
	assign sq_pad   = (CU_DIGITS*DIG)'(sq_q);
	assign digit    = (ctrl.op == bcr_pkg::OP_CU) ? sq_pad[dig_q*DIG +: DIG] :
	                                                mag_pad[dig_q*DIG +: DIG];
	assign prod     = mag_q * digit;
	assign acc_next = acc_q + (ACC_W'(prod) << (DIG * dig_q));
	assign sq_last  = (dig_q == DIGW'(SQ_DIGITS - 1));
	assign cu_last  = (dig_q == DIGW'(CU_DIGITS - 1));

	// exact sign of x^3 - offset * 2^(2*frac)
	always_comb begin
		cube_s = xneg_q ? -$signed(CMP_W'(acc_q)) : $signed(CMP_W'(acc_q));
		off_s  = $signed(CMP_W'(cube_offset)) <<< (2 * FRAC_BITS);
		sgn_now.neg  = cube_s < off_s;
		sgn_now.zero = cube_s == off_s;
	end

	assign sum     = (WORD_BITS+1)'(a_q) + (WORD_BITS+1)'(b_q);
	assign mid     = sum[WORD_BITS:1];
	assign width_s = WID_W'(b_q) - WID_W'(a_q);
	assign tol_s   = $signed(WID_W'(tolerance));
	assign go      = (width_s >= tol_s) && (n_q < CNT'(bcr_pkg::MAX_HALVINGS));

	assign fa_fc_opposite = !fa_q.zero && !sgn_now.zero && (fa_q.neg != sgn_now.neg);

	assign in_ch.ready = (ctrl.op == bcr_pkg::OP_WAIT);
	assign accept      = in_ch.valid && in_ch.ready;
	assign out_busy    = out_valid_q && !out_ch.ready;

	assign status.no_input   = !in_ch.valid;
	assign status.sq_more    = !sq_last;
	assign status.cu_more    = !cu_last;
	assign status.same_sign  = !fa_q.zero && !fb_q.zero && (fa_q.neg == fb_q.neg);
	assign status.stop       = !go;
	assign status.fc_nonzero = !sgn_now.zero;
	assign status.out_busy   = out_busy;

	assign out_ch.valid         = out_valid_q;
	assign out_ch.root_estimate = out_root_q;
	assign out_ch.halving_count = out_cnt_q;
	assign out_ch.no_root       = out_nr_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			bcr_pkg::OP_WAIT: begin
				if (accept) begin
					a_q  <= in_ch.lower_bound;
					b_q  <= in_ch.upper_bound;
					nr_q <= 1'b0;
				end
			end
			bcr_pkg::OP_SETX_A: begin
				mag_q  <= a_q[WORD_BITS-1] ? -a_q : a_q;
				xneg_q <= a_q[WORD_BITS-1];
				acc_q  <= '0;
				dig_q  <= '0;
			end
			bcr_pkg::OP_SETX_B: begin
				mag_q  <= b_q[WORD_BITS-1] ? -b_q : b_q;
				xneg_q <= b_q[WORD_BITS-1];
				acc_q  <= '0;
				dig_q  <= '0;
			end
			bcr_pkg::OP_SQ: begin
				if (sq_last) begin
					sq_q  <= acc_next[SQ_W-1:0];
					acc_q <= '0;
					dig_q <= '0;
				end else begin
					acc_q <= acc_next;
					dig_q <= dig_q + 1'b1;
				end
			end
			bcr_pkg::OP_CU: begin
				acc_q <= acc_next;
				dig_q <= cu_last ? '0 : dig_q + 1'b1;
			end
			bcr_pkg::OP_SIGN_A: fa_q <= sgn_now;
			bcr_pkg::OP_SIGN_B: fb_q <= sgn_now;
			bcr_pkg::OP_CHECK: begin
				if (status.same_sign) begin
					c_q  <= '0;
					n_q  <= '0;
					nr_q <= 1'b1;
				end
			end
			bcr_pkg::OP_INIT: begin
				c_q <= mid;
				n_q <= '0;
			end
			bcr_pkg::OP_TEST: begin
				if (go) begin
					c_q    <= mid;
					mag_q  <= mid[WORD_BITS-1] ? -mid : mid;
					xneg_q <= mid[WORD_BITS-1];
					acc_q  <= '0;
					dig_q  <= '0;
				end
			end
			bcr_pkg::OP_DECIDE: begin
				if (!sgn_now.zero) begin
					if (fa_fc_opposite) begin
						b_q <= c_q;
					end else begin
						a_q  <= c_q;
						fa_q <= sgn_now;
					end
					n_q <= n_q + 1'b1;
				end
			end
			bcr_pkg::OP_EMIT: begin
				if (!out_busy) begin
					out_root_q <= c_q;
					out_cnt_q  <= n_q;
					out_nr_q   <= nr_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == bcr_pkg::OP_EMIT && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== src/bisection_cubic_root_finder.sv =====
// bisection_cubic_root_finder: bisection search for a root of x^3 - cube_offset per interval item
// steps per item: x set, square, cube and sign for the lower then the upper bound, a sign
// check (same signs go to emit), init, then test, square, cube, decide per halving, emit
// one item at a time; the next item is taken once the result sits in the output register
// the step counter, multiply digit counter, multiplier and output back-pressure set the rate; up to 64 halvings
// arst_n clears the sequencer and output valid and loads cube_offset 25.0, tolerance 1678

module bisection_cubic_root_finder #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	bcr_in_if.sink                               in_ch,
	bcr_out_if.source                            out_ch,
	input  logic                                 cfg_we,
	input  logic [bcr_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
	input  logic [bcr_pkg::OFFSET_BITS-1:0]      cfg_wdata
);

	logic signed [bcr_pkg::OFFSET_BITS-1:0] cube_offset_q;
	logic [bcr_pkg::TOL_BITS-1:0]           tolerance_q;
	bcr_pkg::ctrl_t                         ctrl;
	bcr_pkg::status_t                       status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cube_offset_q <= bcr_pkg::CUBE_OFFSET_RESET;
			tolerance_q   <= bcr_pkg::TOLERANCE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				bcr_pkg::CFG_CUBE_OFFSET: cube_offset_q <= $signed(cfg_wdata);
				bcr_pkg::CFG_TOLERANCE:   tolerance_q   <= cfg_wdata[bcr_pkg::TOL_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	bcr_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	bcr_datapath #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.status      (status),
		.cube_offset (cube_offset_q),
		.tolerance   (tolerance_q),
		.in_ch       (in_ch),
		.out_ch      (out_ch)
	);

endmodule

// ===== test/bcr_root_checker.sv =====
`timescale 1ns / 100ps
// bcr_root_checker: watches the interval, result and register ports of the cubic root finder,
// predicts each result from its own register copies and compares it field by field
// depends on bcr_pkg and the channel interfaces in bcr_ifs

module bcr_root_checker #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	bcr_in_if                                in_mon,
	bcr_out_if                               out_mon,
	input  logic                             cfg_we,
	input  logic [bcr_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [bcr_pkg::OFFSET_BITS-1:0]  cfg_wdata,
	output int                               mismatches,
	output int                               results_seen
);

	typedef struct packed {
		logic signed [WORD_BITS-1:0]  root_estimate;
		logic [bcr_pkg::CNT_BITS-1:0] halving_count;
		logic                         no_root;
	} root_result_t;

	logic signed [bcr_pkg::OFFSET_BITS-1:0] offset_q;
	logic [bcr_pkg::TOL_BITS-1:0]           tol_q;
	root_result_t                           expected_roots[$];
	root_result_t                           want;

	initial mismatches = 0;

	task automatic report(input string what);
		mismatches++;
		$display("%0t: %s", $time, what);
	endtask

	// sign of x^3 - offset * 2^(2*frac), exact at full width
	function automatic int cube_sign(input logic signed [WORD_BITS-1:0] x);
		logic signed [127:0] wide_x;
		logic signed [127:0] cube;
		logic signed [127:0] target;
		wide_x = x;
		target = offset_q;
		cube   = wide_x * wide_x * wide_x;
		target = target <<< (2 * FRAC_BITS);
		if (cube > target)
			return 1;
		if (cube < target)
			return -1;
		return 0;
	endfunction

	function automatic root_result_t bisect(input logic signed [WORD_BITS-1:0] lo,
			input logic signed [WORD_BITS-1:0] hi);
		longint       a;
		longint       b;
		longint       c;
		int           fc;
		int           n;
		root_result_t r;
		a = lo;
		b = hi;
		r = '0;
		if (cube_sign(lo) * cube_sign(hi) > 0) begin
			r.no_root = 1'b1;
			return r;
		end
		c = (a + b) >>> 1;
		n = 0;
		while ((b - a) >= longint'(tol_q) && n < bcr_pkg::MAX_HALVINGS) begin
			c  = (a + b) >>> 1;
			fc = cube_sign(c[WORD_BITS-1:0]);
			if (fc == 0)
				break;
			if (cube_sign(a[WORD_BITS-1:0]) * fc < 0)
				b = c;
			else
				a = c;
			n++;
		end
		r.root_estimate = c[WORD_BITS-1:0];
		r.halving_count = n[bcr_pkg::CNT_BITS-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q     <= bcr_pkg::CUBE_OFFSET_RESET;
			tol_q        <= bcr_pkg::TOLERANCE_RESET;
			results_seen <= 0;
			expected_roots.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_idx == bcr_pkg::CFG_CUBE_OFFSET)
					offset_q <= cfg_wdata;
				else if (cfg_idx == bcr_pkg::CFG_TOLERANCE)
					tol_q <= cfg_wdata[bcr_pkg::TOL_BITS-1:0];
			end
			if (out_mon.valid && out_mon.ready) begin
				results_seen <= results_seen + 1;
				if (expected_roots.size() == 0) begin
					report($sformatf("result with no interval pending: root %0d count %0d no_root %0b",
						out_mon.root_estimate, out_mon.halving_count, out_mon.no_root));
				end else begin
					want = expected_roots.pop_front();
					if (out_mon.root_estimate !== want.root_estimate)
						report($sformatf("root_estimate mismatch: expected %0d got %0d",
							want.root_estimate, out_mon.root_estimate));
					if (out_mon.halving_count !== want.halving_count)
						report($sformatf("halving_count mismatch: expected %0d got %0d",
							want.halving_count, out_mon.halving_count));
					if (out_mon.no_root !== want.no_root)
						report($sformatf("no_root mismatch: expected %0b got %0b",
							want.no_root, out_mon.no_root));
				end
			end
			if (in_mon.valid && in_mon.ready)
				expected_roots.push_back(bisect(in_mon.lower_bound, in_mon.upper_bound));
		end
	end

endmodule

// ===== test/bisection_cubic_root_finder_tb.sv =====
`timescale 1ns / 100ps
// bisection_cubic_root_finder_tb: drives intervals and register writes into the root finder
// with random idling on both channels but in the last phase; checking is left to bcr_root_checker
// depends on bcr_pkg, bcr_ifs, the block and bcr_root_checker

module bisection_cubic_root_finder_tb;

	localparam int     WORD_BITS   = 32;
	localparam int     FRAC_BITS   = 24;
	localparam longint CYCLE_LIMIT = 1500000;

	localparam logic signed [WORD_BITS-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [WORD_BITS-1:0] WORD_MAX = 32'sh7fff_ffff;
	localparam logic signed [WORD_BITS-1:0] ONE      = 32'sh0100_0000;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_we;
	logic [bcr_pkg::CFG_IDX_BITS-1:0] cfg_idx;
	logic [bcr_pkg::OFFSET_BITS-1:0]  cfg_wdata;
	int                               mismatches;
	int                               results_seen;
	int                               items_sent = 0;
	longint                           cycles = 0;
	bit                               idle_on = 1'b1;

	bcr_in_if #(.WORD_BITS(WORD_BITS)) in_ch ();
	bcr_out_if #(.WORD_BITS(WORD_BITS)) out_ch ();

	bisection_cubic_root_finder #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	bcr_root_checker #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_mon       (in_ch),
		.out_mon      (out_ch),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.results_seen (results_seen)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : result_sink
		int hold;
		forever begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				out_ch.ready <= 1'b0;
				hold = $urandom_range(1, 13);
			end else begin
				out_ch.ready <= 1'b1;
				hold = $urandom_range(1, 24);
			end
			repeat (hold) @(posedge clk);
		end
	end

	function automatic logic signed [WORD_BITS-1:0] clamp_word(input longint v);
		if (v > longint'(WORD_MAX))
			return WORD_MAX;
		if (v < longint'(WORD_MIN))
			return WORD_MIN;
		return v[WORD_BITS-1:0];
	endfunction

	// distance spread over all magnitudes
	function automatic longint spread();
		return longint'($urandom) >> $urandom_range(1, 32);
	endfunction

	function automatic longint corner(input longint centre);
		case ($urandom_range(0, 5))
			0: return longint'(WORD_MIN);
			1: return longint'(WORD_MAX);
			2: return 0;
			3: return -1;
			4: return 1;
			default: return centre;
		endcase
	endfunction

	task automatic send_interval(input logic signed [WORD_BITS-1:0] lo,
			input logic signed [WORD_BITS-1:0] hi);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.lower_bound <= lo;
		in_ch.upper_bound <= hi;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	task automatic drain(input int settle);
		in_ch.valid <= 1'b0;
		while (results_seen < items_sent)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_config(input logic signed [bcr_pkg::OFFSET_BITS-1:0] off,
			input logic [bcr_pkg::TOL_BITS-1:0] tol);
		cfg_we    <= 1'b1;
		cfg_idx   <= bcr_pkg::CFG_CUBE_OFFSET;
		cfg_wdata <= off;
		@(posedge clk);
		cfg_idx   <= bcr_pkg::CFG_TOLERANCE;
		cfg_wdata <= {1'b0, tol};
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_phase(input logic signed [bcr_pkg::OFFSET_BITS-1:0] off,
			input logic [bcr_pkg::TOL_BITS-1:0] tol, input int count);
		real    scaled;
		longint centre;
		longint lo;
		longint hi;
		int     pick;
		set_config(off, tol);
		scaled = real'(off) * (2.0 ** (2 * FRAC_BITS));
		if (off < 0)
			centre = -longint'((-scaled) ** (1.0 / 3.0));
		else
			centre = longint'(scaled ** (1.0 / 3.0));
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				lo = centre - spread();
				hi = centre + spread();
			end else if (pick < 72) begin
				lo = longint'(int'($urandom));
				hi = longint'(int'($urandom));
			end else if (pick < 84) begin
				lo = centre + $urandom_range(0, 64) - 32;
				hi = lo + $urandom_range(0, 3);
			end else if (pick < 92) begin
				lo = centre + spread();
				hi = centre - spread();
			end else begin
				lo = corner(centre);
				hi = corner(centre);
			end
			send_interval(clamp_word(lo), clamp_word(hi));
		end
		drain(8);
	endtask

	initial begin
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_idx           <= bcr_pkg::CFG_CUBE_OFFSET;
		cfg_wdata         <= '0;
		in_ch.valid       <= 1'b0;
		in_ch.lower_bound <= '0;
		in_ch.upper_bound <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register values after reset
		send_interval(0, 5 * ONE);
		send_interval(WORD_MIN, WORD_MAX);
		send_interval(WORD_MAX, WORD_MIN);
		send_interval(-5 * ONE, -1 * ONE);
		send_interval(4 * ONE, 8 * ONE);
		send_interval(5 * ONE, 4 * ONE);
		send_interval(5 * ONE, 0);
		send_interval(2 * ONE, 3 * ONE);
		drain(8);

		// exact root at 2.0: midpoint hit, roots at either end, empty interval on the root
		set_config(8 * ONE, bcr_pkg::TOLERANCE_RESET);
		send_interval(0, 4 * ONE);
		send_interval(2 * ONE, 5 * ONE);
		send_interval(-1 * ONE, 2 * ONE);
		send_interval(2 * ONE, 2 * ONE);
		drain(8);

		// root at zero with the finest tolerance, one-wide interval stuck at the limit
		set_config(0, 1);
		send_interval(-1, 0);
		send_interval(-1 * ONE, ONE);
		send_interval(WORD_MIN, WORD_MAX);
		send_interval(0, 0);
		send_interval(-3, 7);
		drain(8);

		set_config(WORD_MAX, 31'h7fff_ffff);
		send_interval(WORD_MIN, WORD_MAX);
		send_interval(0, WORD_MAX);
		drain(8);

		set_config(WORD_MIN, bcr_pkg::TOLERANCE_RESET);
		send_interval(WORD_MIN, WORD_MAX);
		send_interval(WORD_MIN, 0);
		drain(8);

		random_phase(bcr_pkg::CUBE_OFFSET_RESET, bcr_pkg::TOLERANCE_RESET, 120);
		random_phase(0, 1, 110);
		random_phase(WORD_MAX, 1, 110);
		random_phase(WORD_MIN, 31'd65536, 110);
		random_phase($urandom, 31'h7fff_ffff, 100);
		random_phase($urandom, 31'($urandom_range(1, 32'h7fff_ffff)), 120);
		random_phase(-8 * ONE, 31'($urandom_range(1, 64)), 110);
		idle_on = 1'b0;
		random_phase($urandom, bcr_pkg::TOLERANCE_RESET, 80);

		drain(400);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
src/bcr_pkg.sv
src/bcr_ifs.sv
src/bcr_sequencer.sv
src/bcr_datapath.sv
src/bisection_cubic_root_finder.sv
test/bcr_root_checker.sv
test/bisection_cubic_root_finder_tb.sv
